[src/mftt_pkg.sv]
// Package for the motor feedback turn tracker: field widths, slot count,
// item, result and configuration types. No dependencies.
package mftt_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MASK_W     = 8;

  localparam int ID_W    = 11;
  localparam int ANGLE_W = 16;
  localparam int SPEED_W = 16;
  localparam int CURR_W  = 16;
  localparam int TEMP_W  = 8;
  localparam int TURN_W  = 24;
  localparam int POS_W   = 37;
  localparam int SIDX_W  = 3;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [ID_W-1:0]   BASE_ID_RESET    = 11'h201;
  localparam logic [MASK_W-1:0] ENABLE_RESET     = 8'h00;
  localparam logic [TEMP_W-1:0] TEMP_LIMIT_RESET = 8'd100;

  localparam logic signed [ANGLE_W:0]  WRAP_STEP = 17'sd4096;
  localparam logic signed [TURN_W-1:0] TURN_MAX  = 24'sh7FFFFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN  = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ID    = 2'd0,
    REG_ENABLE     = 2'd1,
    REG_TEMP_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_W-1:0]   base_identifier;
    logic [MASK_W-1:0] slot_enable_mask;
    logic [TEMP_W-1:0] temperature_limit;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0]         temperature_raw;
    logic signed [CURR_W-1:0]  current_raw;
    logic signed [SPEED_W-1:0] speed_raw;
    logic [ANGLE_W-1:0]        angle_raw;
    logic [ID_W-1:0]           frame_identifier;
  } item_t;

  typedef struct packed {
    logic                      hit;
    logic                      over_temperature;
    logic [TEMP_W-1:0]         temperature_out;
    logic signed [CURR_W-1:0]  current_out;
    logic signed [SPEED_W-1:0] speed_out;
    logic signed [POS_W-1:0]   extended_position;
    logic [SIDX_W-1:0]         slot_index;
  } result_t;

endpackage

[src/motor_feedback_turn_tracker_unit.sv]
// Top level of the motor feedback turn tracker: input register, slot tracker
// and result register. Depends on mftt_pkg, mftt_cfg_regs, mftt_slot_track.
//
//   channel   handshake              payload
//   s_axis    s_tvalid / s_tready    s_tdata: feedback frame
//   m_axis    m_tvalid / m_tready    m_tdata: result, m_tuser: hit
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One frame per cycle while the result side is not stalled; a frame passes
// from the input register through the slot state read-modify-write into the
// result register. Reset is synchronous and clears both valid flags,
// the configuration and all slot state. A stalled result holds while one more
// frame waits in the input register.
module motor_feedback_turn_tracker_unit
  import mftt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [10:0] frame_identifier, [26:11] angle_raw, [42:27] speed_raw,
  // [58:43] current_raw, [66:59] temperature_raw, [71:67] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [2:0] slot_index, [39:3] extended_position, [55:40] speed_out,
  // [71:56] current_out, [79:72] temperature_out, [80] over_temperature,
  // [87:81] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [0] hit
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t result_q;

  mftt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_t'(s_tdata[$bits(item_t)-1:0]);
    end
  end

  mftt_slot_track u_track (
    .clk    (clk),
    .rst    (rst),
    .update (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_tuser = result_q.hit;
  assign m_tdata = {{(OUT_DATA_W - $bits(result_t) + 1){1'b0}},
                    result_q[$bits(result_t)-2:0]};

endmodule

[src/mftt_cfg_regs.sv]
// Configuration registers of the turn tracker.
// Depends on mftt_pkg.
module mftt_cfg_regs
  import mftt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_identifier   <= BASE_ID_RESET;
      cfg.slot_enable_mask  <= ENABLE_RESET;
      cfg.temperature_limit <= TEMP_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_ID:    cfg.base_identifier   <= cfg_data[ID_W-1:0];
        REG_ENABLE:     cfg.slot_enable_mask  <= cfg_data[MASK_W-1:0];
        REG_TEMP_LIMIT: cfg.temperature_limit <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/mftt_slot_track.sv]
// Per-slot state (seen flag, last angle, turn count), unwrap update and
// result formation for one registered item. Depends on mftt_pkg.
module mftt_slot_track
  import mftt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    update,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic                      slot_seen  [SLOT_COUNT];
  logic [ANGLE_W-1:0]        last_angle [SLOT_COUNT];
  logic signed [TURN_W-1:0]  turn_count [SLOT_COUNT];

  logic [ID_W-1:0]           offset;
  logic [SLOT_W-1:0]         slot;
  logic                      hit;
  logic signed [ANGLE_W:0]   diff;
  logic signed [TURN_W-1:0]  turn_cur;
  logic signed [TURN_W-1:0]  turn_next;
  logic signed [POS_W-1:0]   turn_ext;
  logic signed [POS_W-1:0]   position;

  always_comb begin
    offset = item.frame_identifier - cfg.base_identifier;
    slot   = offset[SLOT_W-1:0];
    hit    = (item.frame_identifier >= cfg.base_identifier)
          && (offset < ID_W'(SLOT_COUNT))
          && (offset < ID_W'(MASK_W))
          && cfg.slot_enable_mask[offset[SIDX_W-1:0]];
  end

  always_comb begin
    turn_cur  = turn_count[slot];
    diff      = $signed({1'b0, item.angle_raw}) - $signed({1'b0, last_angle[slot]});
    turn_next = turn_cur;
    if (slot_seen[slot]) begin
      if (diff > WRAP_STEP) begin
        if (turn_cur != TURN_MIN) turn_next = turn_cur - TURN_W'(1);
      end else if (diff < -WRAP_STEP) begin
        if (turn_cur != TURN_MAX) turn_next = turn_cur + TURN_W'(1);
      end
    end
    turn_ext = POS_W'(turn_next);
    position = $signed({{(POS_W-ANGLE_W){1'b0}}, item.angle_raw})
             + (turn_ext <<< 13) - turn_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_seen[s]  <= 1'b0;
        last_angle[s] <= '0;
        turn_count[s] <= '0;
      end
    end else if (update && hit) begin
      slot_seen[slot]  <= 1'b1;
      last_angle[slot] <= item.angle_raw;
      turn_count[slot] <= turn_next;
    end
  end

  always_comb begin
    result = '0;
    if (hit) begin
      result.hit               = 1'b1;
      result.slot_index        = offset[SIDX_W-1:0];
      result.extended_position = position;
      result.speed_out         = item.speed_raw;
      result.current_out       = item.current_raw;
      result.temperature_out   = item.temperature_raw;
      result.over_temperature  = item.temperature_raw > cfg.temperature_limit;
    end
  end

endmodule

[sim/mftt_result_checker.sv]
// Result checker for the motor feedback turn tracker: follows the register
// and frame transfers, predicts each result and compares the result stream.
// Depends on mftt_pkg.
`timescale 1ns / 100ps

module mftt_result_checker
  import mftt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending_results,
  output int                    error_count
);

  localparam int     ANGLE_JUMP      = 4096;
  localparam longint COUNTS_PER_TURN = 8191;

  cfg_t                      cfg;
  logic                      seen       [SLOT_COUNT];
  logic [ANGLE_W-1:0]        prev_angle [SLOT_COUNT];
  logic signed [TURN_W-1:0]  turns      [SLOT_COUNT];
  result_t                   expected_results [$];

  initial begin
    pending_results = 0;
    error_count     = 0;
  end

  function automatic result_t track_frame(input item_t f);
    result_t r;
    int      slot;
    int      jump;
    longint  pos;
    r = '0;
    if (f.frame_identifier < cfg.base_identifier) return r;
    slot = int'(f.frame_identifier) - int'(cfg.base_identifier);
    if (slot >= SLOT_COUNT || slot >= MASK_W) return r;
    if (!cfg.slot_enable_mask[slot]) return r;
    if (seen[slot]) begin
      jump = int'(f.angle_raw) - int'(prev_angle[slot]);
      if (jump > ANGLE_JUMP) begin
        if (turns[slot] != TURN_MIN) turns[slot] = turns[slot] - TURN_W'(1);
      end else if (jump < -ANGLE_JUMP) begin
        if (turns[slot] != TURN_MAX) turns[slot] = turns[slot] + TURN_W'(1);
      end
    end
    seen[slot]       = 1'b1;
    prev_angle[slot] = f.angle_raw;
    pos = longint'(f.angle_raw) + COUNTS_PER_TURN * longint'(turns[slot]);
    r.hit               = 1'b1;
    r.slot_index        = slot[SIDX_W-1:0];
    r.extended_position = pos[POS_W-1:0];
    r.speed_out         = f.speed_raw;
    r.current_out       = f.current_raw;
    r.temperature_out   = f.temperature_raw;
    r.over_temperature  = f.temperature_raw > cfg.temperature_limit;
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      cfg = '{BASE_ID_RESET, ENABLE_RESET, TEMP_LIMIT_RESET};
      for (int s = 0; s < SLOT_COUNT; s++) begin
        seen[s]       = 1'b0;
        prev_angle[s] = '0;
        turns[s]      = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_BASE_ID:    cfg.base_identifier   = cfg_data[ID_W-1:0];
          REG_ENABLE:     cfg.slot_enable_mask  = cfg_data[MASK_W-1:0];
          REG_TEMP_LIMIT: cfg.temperature_limit = cfg_data[TEMP_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[$bits(result_t)-2:0]};
        if (expected_results.size() == 0) begin
          $error("result transfer with no frame outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("hit", want.hit, got.hit);
          compare_field("slot_index", want.slot_index, got.slot_index);
          compare_field("extended_position", longint'(want.extended_position),
                        longint'(got.extended_position));
          compare_field("speed_out", longint'(want.speed_out), longint'(got.speed_out));
          compare_field("current_out", longint'(want.current_out),
                        longint'(got.current_out));
          compare_field("temperature_out", want.temperature_out, got.temperature_out);
          compare_field("over_temperature", want.over_temperature, got.over_temperature);
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(track_frame(item_t'(s_tdata[$bits(item_t)-1:0])));
    end
    pending_results = expected_results.size();
  end

endmodule

[sim/motor_feedback_turn_tracker_unit_tb.sv]
// Testbench top for the motor feedback turn tracker: clock, reset, register
// writes, frame and result stream traffic, and the verdict.
// Depends on mftt_pkg, motor_feedback_turn_tracker_unit, mftt_result_checker.
`timescale 1ns / 100ps

module motor_feedback_turn_tracker_unit_tb;
  import mftt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;
  localparam int                   CYCLE_LIMIT    = 400000;
  localparam int                   PHASE_COUNT    = 6;
  localparam int                   FRAMES_PER_RUN = 238;
  localparam int                   LONG_HOLD      = 300;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    pending_results;
  int                    error_count;
  int                    cycle_count;

  logic [ID_W-1:0]    cur_base  = BASE_ID_RESET;
  logic [MASK_W-1:0]  cur_mask  = ENABLE_RESET;
  logic [TEMP_W-1:0]  cur_limit = TEMP_LIMIT_RESET;
  logic [ANGLE_W-1:0] walk_angle [SLOT_COUNT];
  int                 burst_left = 0;
  bit                 no_gaps    = 1'b0;
  logic               long_hold_req = 1'b0;
  bit                 long_hold_done = 1'b0;
  int                 hold_left  = 0;
  rx_mode_t           rx_mode    = RX_OPEN;
  int                 mode_left  = 0;

  always #2 clk = ~clk;

  motor_feedback_turn_tracker_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mftt_result_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .error_count     (error_count)
  );

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: changing stall patterns, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  task automatic send_frame(input item_t f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - $bits(item_t)){1'b0}}, f};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_fields(input int id, input int angle, input int speed,
                             input int current, input int temp);
    item_t f;
    f.frame_identifier = ID_W'(id);
    f.angle_raw        = ANGLE_W'(angle);
    f.speed_raw        = SPEED_W'(speed);
    f.current_raw      = CURR_W'(current);
    f.temperature_raw  = TEMP_W'(temp);
    send_frame(f);
  endtask

  // hold the sender until every result is back, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [ID_W-1:0] base, input logic [MASK_W-1:0] mask,
                              input logic [TEMP_W-1:0] limit);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_SPARE, REG_BASE_ID, REG_ENABLE, REG_TEMP_LIMIT};
    val[0] = CFG_DATA_W'($urandom);
    val[1] = base;
    val[2] = {3'($urandom), mask};
    val[3] = {3'($urandom), limit};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_base  = base;
    cur_mask  = mask;
    cur_limit = limit;
  endtask

  task automatic random_frame(output item_t f);
    int slot;
    int idv;
    int step;
    int sgn;
    slot = $urandom_range(0, SLOT_COUNT - 1);
    if (cur_mask != '0)
      while (!cur_mask[slot]) slot = $urandom_range(0, SLOT_COUNT - 1);
    idv = int'(cur_base) + slot;
    if ($urandom_range(0, 99) >= 85) begin
      case ($urandom_range(0, 3))
        0:       idv = int'(cur_base) - 1;
        1:       idv = int'(cur_base) + SLOT_COUNT + $urandom_range(0, 2);
        2:       idv = int'(cur_base) + $urandom_range(0, SLOT_COUNT - 1);
        default: idv = $urandom_range(0, 2047);
      endcase
    end
    if (idv < 0 || idv > 2047) idv = $urandom_range(0, 2047);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: step = $urandom_range(0, 4000) - 2000;
      6, 7:             step = sgn * (4097 + $urandom_range(0, 12000));
      8:                step = sgn * (4096 + $urandom_range(0, 1));
      default:          step = $urandom_range(0, 65535);
    endcase
    walk_angle[slot] = walk_angle[slot] + ANGLE_W'(step);
    f.frame_identifier = ID_W'(idv);
    f.angle_raw        = walk_angle[slot];
    f.speed_raw        = SPEED_W'($urandom);
    f.current_raw      = CURR_W'($urandom);
    f.temperature_raw  = ($urandom_range(0, 3) == 0) ? cur_limit + TEMP_W'($urandom_range(0, 1))
                                                      : TEMP_W'($urandom);
  endtask

  initial begin
    item_t f;
    for (int s = 0; s < SLOT_COUNT; s++) walk_angle[s] = ANGLE_W'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no slot enabled
    send_fields(11'h201, 1000, 5, -5, 200);
    send_fields(11'h200, 2000, 0, 0, 0);
    wait_drained();

    write_config(11'd0, 8'hFF, 8'd0);
    send_fields(0, 0, 0, 0, 0);
    send_fields(0, 65535, 32767, -32768, 255);
    send_fields(0, 0, -32768, 32767, 1);
    send_fields(0, 4096, 1, -1, 0);
    send_fields(0, 0, 0, 0, 0);
    send_fields(0, 4097, 0, 0, 0);
    send_fields(0, 0, 0, 0, 0);
    send_fields(0, 60000, 0, 0, 0);
    send_fields(0, 55000, 0, 0, 0);
    send_fields(0, 0, 0, 0, 0);
    send_fields(7, 1234, 100, 200, 50);
    send_fields(8, 1234, 100, 200, 50);
    send_fields(2047, 65535, -1, -1, 255);
    wait_drained();

    write_config(11'd2047, 8'h01, 8'd255);
    send_fields(2047, 100, 7, 7, 255);
    send_fields(2046, 100, 7, 7, 255);
    send_fields(0, 100, 7, 7, 255);
    wait_drained();

    write_config(11'd2040, 8'h80, 8'd128);
    send_fields(2047, 30000, 3, 3, 128);
    send_fields(2047, 40000, 3, 3, 129);
    send_fields(2046, 40000, 3, 3, 129);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       write_config(11'd0, 8'hFF, 8'd0);
        1:       write_config(ID_W'($urandom), MASK_W'($urandom), TEMP_W'($urandom));
        2:       write_config(11'd2047, 8'h01, 8'd255);
        3:       write_config(11'd2040, 8'hFF, TEMP_W'($urandom));
        4:       write_config(BASE_ID_RESET, MASK_W'($urandom), TEMP_LIMIT_RESET);
        default: write_config(ID_W'($urandom_range(0, 2040)), 8'hFF, TEMP_W'($urandom));
      endcase
      if (p == 1) begin
        no_gaps = 1'b1;
        long_hold_req <= 1'b1;
      end
      for (int n = 0; n < FRAMES_PER_RUN; n++) begin
        random_frame(f);
        send_frame(f);
      end
      no_gaps = 1'b0;
      wait_drained();
    end

    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[motor_feedback_turn_tracker_unit.f]
src/mftt_pkg.sv
src/mftt_cfg_regs.sv
src/mftt_slot_track.sv
src/motor_feedback_turn_tracker_unit.sv
sim/mftt_result_checker.sv
sim/motor_feedback_turn_tracker_unit_tb.sv
